// ===== rtl/a2dtu_pkg.sv =====
// Shared types for the 2D affine transform unit.
// Holds the request codes and the sequencer state encoding; no dependencies.
package a2dtu_pkg;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_COMPOSE = 2'd1,
        REQ_INVERT  = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_INIT  = 10'b00_0000_0010,
        ST_MLOAD = 10'b00_0000_0100,
        ST_MUL   = 10'b00_0000_1000,
        ST_MACC  = 10'b00_0001_0000,
        ST_POST  = 10'b00_0010_0000,
        ST_DSET  = 10'b00_0100_0000,
        ST_DIV   = 10'b00_1000_0000,
        ST_DQ    = 10'b01_0000_0000,
        ST_DONE  = 10'b10_0000_0000
    } state_t;

endpackage

// ===== rtl/affine_2d_transform_unit.sv =====
// Top level of the 2D affine transform unit: stored transform, sequencer,
// shared digit multiplier and restoring divider. Depends on a2dtu_pkg.
//
// The block holds one 2D affine transform (2x2 linear part plus translation) as
// six signed fixed-point entries of ENTRY_WIDTH bits with FRAC_BITS fraction
// bits, reset to identity. Each accepted word carries one request: load
// replaces the transform, compose post-multiplies it by the input transform
// (adding the input translation), and invert replaces it with its inverse.
// When the determinant magnitude is below 1e-6 the inverse becomes identity
// and singular is raised. Results round to nearest with ties away from zero
// and saturate to the entry range, raising overflow. Every request returns one
// result word with the stored transform after the operation. The block takes
// one word at a time: s_ready is high only while the sequencer is idle. All
// arithmetic runs through one shared multiplier (entry magnitude times a
// 16-bit digit, one digit per cycle) and one restoring divider (one quotient
// bit per cycle). A load or an unused request goes straight to the result word; a
// compose runs two products per entry; an invert forms the determinant from two
// products, then divides for each entry, the translation entries after two more
// products. With ENTRY_WIDTH up to 32 and Q16.16 each division is 99 bits wide.
// A singular invert finishes after the determinant. A finished result waits in
// the output register until m_ready takes it, and the sequencer holds in its last
// state while the previous word is unread.
module affine_2d_transform_unit
    import a2dtu_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_in_m00,
    input  logic [31:0] s_in_m01,
    input  logic [31:0] s_in_m10,
    input  logic [31:0] s_in_m11,
    input  logic [31:0] s_in_tx,
    input  logic [31:0] s_in_ty,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_out_m00,
    output logic [31:0] m_out_m01,
    output logic [31:0] m_out_m10,
    output logic [31:0] m_out_m11,
    output logic [31:0] m_out_tx,
    output logic [31:0] m_out_ty,
    output logic        m_singular,
    output logic        m_overflow
);

    localparam int EW  = ENTRY_WIDTH;
    localparam int F   = FRAC_BITS;
    // Multiplier operand width: inputs are 32 bits, stored entries EW bits.
    localparam int MW  = (EW > 32) ? EW : 32;
    localparam int ND  = (MW + 15) / 16;
    localparam int YPW = ND * 16;
    localparam int PW  = YPW + MW;
    // Accumulator: sum of two full products shifted by F, or an entry << 2F.
    localparam int AW  = 2 * MW + 2 * F + 2;
    localparam int NB  = AW + 1;
    localparam int DW  = 2 * MW + 1;
    localparam int CW  = $clog2(NB + 1);

    localparam logic [63:0] ONE64 = (F >= EW - 1) ? ((64'd1 << (EW - 1)) - 64'd1)
                                                  : (64'd1 << F);
    localparam logic [EW-1:0] ONE_V = ONE64[EW-1:0];
    localparam logic [63:0] THR = ((64'd1 << (2 * F)) + 64'd999999) / 64'd1000000;
    localparam logic [NB-1:0] LIM = NB'(1) << (EW - 1);

    // Saturate a sign and magnitude to EW bits; the top bit flags clipping.
    function automatic logic [EW:0] sat_fn(input logic neg, input logic [NB-1:0] mag);
        logic [NB-1:0] negm;
        logic [EW:0]   r;
        negm = -mag;
        if (neg) begin
            if (mag > LIM) begin
                r = {1'b1, 1'b1, {(EW - 1){1'b0}}};
            end else begin
                r = {1'b0, negm[EW-1:0]};
            end
        end else begin
            if (mag > LIM - NB'(1)) begin
                r = {1'b1, 1'b0, {(EW - 1){1'b1}}};
            end else begin
                r = {1'b0, mag[EW-1:0]};
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] to_out(input logic signed [EW-1:0] v);
        logic signed [MW-1:0] x;
        x = MW'(v);
        return x[31:0];
    endfunction

    state_t state_reg;
    req_t   op_reg;

    logic signed [EW-1:0] t_reg [6];
    logic signed [EW-1:0] n_reg [6];
    logic signed [MW-1:0] b_reg [6];
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] det_reg;
    logic [MW-1:0]        mx_reg;
    logic [YPW-1:0]       my_reg;
    logic                 mneg_reg;
    logic [PW-1:0]        prod_reg;
    logic [NB-1:0]        num_reg;
    logic [DW-1:0]        den_reg;
    logic [DW:0]          rem_reg;
    logic                 qneg_reg;
    logic [CW-1:0]        cnt_reg;
    logic [2:0]           e_reg;
    logic                 p_reg;
    logic                 det_phase_reg;
    logic                 ovf_reg;
    logic                 sing_reg;

    logic        m_valid_reg;
    logic [31:0] out_reg [6];
    logic        sing_out_reg;
    logic        ovf_out_reg;

    // Input words sign-extended to the multiplier width.
    logic [31:0]          in_w [6];
    logic signed [MW-1:0] in_ext [6];
    logic [EW-1:0]        load_v [6];
    logic                 load_ovf;

    always_comb begin
        logic [EW:0]   s;
        logic [32:0]   m;
        in_w[0] = s_in_m00;
        in_w[1] = s_in_m01;
        in_w[2] = s_in_m10;
        in_w[3] = s_in_m11;
        in_w[4] = s_in_tx;
        in_w[5] = s_in_ty;
        load_ovf = 1'b0;
        for (int i = 0; i < 6; i++) begin
            in_ext[i] = MW'($signed(in_w[i]));
            m = in_w[i][31] ? (33'd0 - {1'b1, in_w[i]}) : {1'b0, in_w[i]};
            s = sat_fn(in_w[i][31], NB'(m));
            load_v[i] = s[EW-1:0];
            load_ovf  = load_ovf | s[EW];
        end
    end

    // Operand selection for the shared multiplier.
    logic signed [MW-1:0] ax [6];
    logic signed [MW-1:0] x_val;
    logic signed [MW-1:0] y_val;
    logic                 neg_sel;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            ax[i] = MW'(t_reg[i]);
        end
        x_val   = ax[{e_reg[2:1], p_reg}];
        y_val   = b_reg[{p_reg, e_reg[0]}];
        neg_sel = 1'b0;
        if (op_reg == REQ_INVERT) begin
            neg_sel = p_reg;
            if (det_phase_reg) begin
                x_val = p_reg ? ax[2] : ax[0];
                y_val = p_reg ? ax[1] : ax[3];
            end else if (e_reg == 3'd4) begin
                x_val = p_reg ? ax[3] : ax[2];
                y_val = p_reg ? ax[4] : ax[5];
            end else begin
                x_val = p_reg ? ax[0] : ax[1];
                y_val = p_reg ? ax[5] : ax[4];
            end
        end
    end

    logic [AW-1:0] acc_mag;
    logic [AW-1:0] det_mag;
    logic [NB-1:0] rnd_mag;
    logic [EW:0]   post_sat;
    logic [EW:0]   div_sat;
    logic [DW:0]   rem_sh;
    logic [15:0]   digit;

    always_comb begin
        acc_mag  = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);
        det_mag  = det_reg[AW-1] ? AW'(-det_reg) : AW'(det_reg);
        // Half an LSB is added to the magnitude, so ties round away from zero.
        rnd_mag  = (NB'(acc_mag) + (NB'(1) << (F - 1))) >> F;
        post_sat = sat_fn(acc_reg[AW-1], rnd_mag);
        div_sat  = sat_fn(qneg_reg, num_reg);
        rem_sh   = {rem_reg[DW-1:0], num_reg[NB-1]};
        digit    = my_reg[YPW-1 -: 16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            det_phase_reg <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                t_reg[i] <= (i == 0 || i == 3) ? ONE_V : '0;
            end
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg        <= req_t'(s_req_type);
                        ovf_reg       <= (req_t'(s_req_type) == REQ_LOAD) ? load_ovf : 1'b0;
                        sing_reg      <= 1'b0;
                        e_reg         <= 3'd0;
                        det_phase_reg <= (req_t'(s_req_type) == REQ_INVERT);
                        for (int i = 0; i < 6; i++) begin
                            b_reg[i] <= in_ext[i];
                            n_reg[i] <= (req_t'(s_req_type) == REQ_LOAD) ? load_v[i]
                                                                         : t_reg[i];
                        end
                        unique case (req_t'(s_req_type))
                            REQ_LOAD:    state_reg <= ST_DONE;
                            REQ_COMPOSE: state_reg <= ST_INIT;
                            REQ_INVERT:  state_reg <= ST_INIT;
                            default:     state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_INIT: begin
                    p_reg <= 1'b0;
                    if (op_reg == REQ_COMPOSE) begin
                        acc_reg   <= (e_reg >= 3'd4) ? (AW'(b_reg[e_reg]) <<< F) : '0;
                        state_reg <= ST_MLOAD;
                    end else if (det_phase_reg || e_reg >= 3'd4) begin
                        acc_reg   <= '0;
                        state_reg <= ST_MLOAD;
                    end else begin
                        // Cofactors of the 2x2 part, scaled by 2F fraction bits.
                        case (e_reg)
                            3'd0:    acc_reg <= AW'(t_reg[3]) <<< (2 * F);
                            3'd1:    acc_reg <= -(AW'(t_reg[1]) <<< (2 * F));
                            3'd2:    acc_reg <= -(AW'(t_reg[2]) <<< (2 * F));
                            default: acc_reg <= AW'(t_reg[0]) <<< (2 * F);
                        endcase
                        state_reg <= ST_DSET;
                    end
                end
                ST_MLOAD: begin
                    mx_reg    <= x_val[MW-1] ? MW'(-x_val) : MW'(x_val);
                    my_reg    <= y_val[MW-1] ? YPW'(MW'(-y_val)) : YPW'(MW'(y_val));
                    mneg_reg  <= x_val[MW-1] ^ y_val[MW-1] ^ neg_sel;
                    prod_reg  <= '0;
                    cnt_reg   <= CW'(ND);
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    // Most significant digit first: shift then add one partial.
                    prod_reg <= (prod_reg << 16) + PW'(mx_reg * digit);
                    my_reg   <= my_reg << 16;
                    cnt_reg  <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        state_reg <= ST_MACC;
                    end
                end
                ST_MACC: begin
                    acc_reg <= mneg_reg ? (acc_reg - AW'(prod_reg)) : (acc_reg + AW'(prod_reg));
                    if (!p_reg) begin
                        p_reg     <= 1'b1;
                        state_reg <= ST_MLOAD;
                    end else begin
                        state_reg <= ST_POST;
                    end
                end
                ST_POST: begin
                    if (op_reg == REQ_COMPOSE) begin
                        n_reg[e_reg] <= post_sat[EW-1:0];
                        ovf_reg      <= ovf_reg | post_sat[EW];
                        e_reg        <= e_reg + 3'd1;
                        state_reg    <= (e_reg == 3'd5) ? ST_DONE : ST_INIT;
                    end else if (det_phase_reg) begin
                        det_reg <= acc_reg;
                        if (acc_mag < AW'(THR)) begin
                            for (int i = 0; i < 6; i++) begin
                                n_reg[i] <= (i == 0 || i == 3) ? ONE_V : '0;
                            end
                            sing_reg  <= 1'b1;
                            state_reg <= ST_DONE;
                        end else begin
                            det_phase_reg <= 1'b0;
                            e_reg         <= 3'd0;
                            state_reg     <= ST_INIT;
                        end
                    end else begin
                        acc_reg   <= acc_reg <<< F;
                        state_reg <= ST_DSET;
                    end
                end
                ST_DSET: begin
                    // Rounded division: (2|n| + |d|) / (2|d|), sign applied after.
                    num_reg   <= NB'({acc_mag, 1'b0}) + NB'(det_mag);
                    den_reg   <= {det_mag[DW-2:0], 1'b0};
                    rem_reg   <= '0;
                    qneg_reg  <= acc_reg[AW-1] ^ det_reg[AW-1];
                    cnt_reg   <= CW'(NB);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (rem_sh >= {1'b0, den_reg}) begin
                        rem_reg <= rem_sh - {1'b0, den_reg};
                        num_reg <= {num_reg[NB-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        num_reg <= {num_reg[NB-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        state_reg <= ST_DQ;
                    end
                end
                ST_DQ: begin
                    n_reg[e_reg] <= div_sat[EW-1:0];
                    ovf_reg      <= ovf_reg | div_sat[EW];
                    e_reg        <= e_reg + 3'd1;
                    state_reg    <= (e_reg == 3'd5) ? ST_DONE : ST_INIT;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        for (int i = 0; i < 6; i++) begin
                            t_reg[i]   <= n_reg[i];
                            out_reg[i] <= to_out(n_reg[i]);
                        end
                        sing_out_reg <= sing_reg;
                        ovf_out_reg  <= ovf_reg;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_out_m00  = out_reg[0];
    assign m_out_m01  = out_reg[1];
    assign m_out_m10  = out_reg[2];
    assign m_out_m11  = out_reg[3];
    assign m_out_tx   = out_reg[4];
    assign m_out_ty   = out_reg[5];
    assign m_singular = sing_out_reg;
    assign m_overflow = ovf_out_reg;

endmodule

// ===== dv/affine_2d_transform_unit_tb.sv =====
// Self-checking testbench for the 2D affine transform unit (load, compose, invert).
// Depends on a2dtu_pkg and rtl/affine_2d_transform_unit.sv; needs no other files.
module affine_2d_transform_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import a2dtu_pkg::*;

    localparam int FRAC = 16;
    localparam int N_RANDOM = 1530;
    localparam int N_CALM = 150;
    // The slowest request is an invert; add a full receiver stall and the
    // sender gap, then take it several times over.
    localparam int STALL_LIMIT = 5000;
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;

    typedef logic [5:0][31:0] xform_t;   // m00 m01 m10 m11 tx ty, index 0 first
    typedef struct packed {
        xform_t m;
        logic   sing;
        logic   ovf;
    } result_t;
    typedef struct {
        req_t    op;
        xform_t  v;
        bit      typed;
        result_t want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = '0;
    logic [31:0] s_in_m00 = '0, s_in_m01 = '0, s_in_m10 = '0;
    logic [31:0] s_in_m11 = '0, s_in_tx = '0, s_in_ty = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_out_m00, m_out_m01, m_out_m10, m_out_m11, m_out_tx, m_out_ty;
    logic        m_singular, m_overflow;

    affine_2d_transform_unit dut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Predictor state: the transform the block should be holding right now.
    logic signed [31:0] held [6];
    result_t            want_q[$];
    row_t               rows[$];
    int                 errors = 0;
    int                 op_count[4] = '{0, 0, 0, 0};
    int                 sing_seen = 0, ovf_seen = 0;
    bit                 calm = 1'b0;
    bit                 stim_done = 1'b0;
    int                 idle_cycles = 0;

    function automatic xform_t mk(logic [31:0] m00, logic [31:0] m01, logic [31:0] m10,
                                  logic [31:0] m11, logic [31:0] tx, logic [31:0] ty);
        xform_t x;
        x[0] = m00; x[1] = m01; x[2] = m10; x[3] = m11; x[4] = tx; x[5] = ty;
        return x;
    endfunction

    // Clamp a wide value to the signed 32-bit entry range, flagging overflow.
    function automatic logic signed [31:0] clamp32(logic signed [127:0] v, ref logic ovf);
        if (v > 128'sd2147483647) begin
            ovf = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -128'sd2147483648) begin
            ovf = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Drop FRAC fraction bits, rounding half away from zero.
    function automatic logic signed [127:0] drop_frac(logic signed [127:0] v);
        logic signed [127:0] mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
        return (v < 0) ? -mag : mag;
    endfunction

    // Exact quotient, rounded half away from zero.
    function automatic logic signed [127:0] div_round(logic signed [127:0] n,
                                                      logic signed [127:0] d);
        logic [127:0] mn, md, q;
        mn = (n < 0) ? -n : n;
        md = (d < 0) ? -d : d;
        q = (2 * mn + md) / (2 * md);
        return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic void hold_identity();
        foreach (held[i]) held[i] = '0;
        held[0] = ONE;
        held[3] = ONE;
    endfunction

    // Applies one request to the held transform and returns the result word.
    function automatic result_t apply_request(req_t op, xform_t v);
        logic signed [127:0] a[6], b[6], s[6];
        logic signed [127:0] det, mag;
        logic ovf, sing;
        result_t r;
        ovf = 1'b0;
        sing = 1'b0;
        foreach (a[i]) begin
            a[i] = held[i];
            b[i] = $signed(v[i]);
        end
        case (op)
            REQ_LOAD: begin
                foreach (held[i]) held[i] = v[i];
            end
            REQ_COMPOSE: begin
                s[0] = a[0] * b[0] + a[1] * b[2];
                s[1] = a[0] * b[1] + a[1] * b[3];
                s[2] = a[2] * b[0] + a[3] * b[2];
                s[3] = a[2] * b[1] + a[3] * b[3];
                s[4] = a[4] * b[0] + a[5] * b[2] + (b[4] <<< FRAC);
                s[5] = a[4] * b[1] + a[5] * b[3] + (b[5] <<< FRAC);
                foreach (held[i]) held[i] = clamp32(drop_frac(s[i]), ovf);
            end
            REQ_INVERT: begin
                det = a[0] * a[3] - a[2] * a[1];
                mag = (det < 0) ? -det : det;
                // |det| below 1e-6 in Q32 means below ceil(2^32 / 1e6).
                if (mag < 128'sd4295) begin
                    sing = 1'b1;
                    hold_identity();
                end else begin
                    s[0] = div_round(a[3] <<< (2 * FRAC), det);
                    s[1] = div_round((-a[1]) <<< (2 * FRAC), det);
                    s[2] = div_round((-a[2]) <<< (2 * FRAC), det);
                    s[3] = div_round(a[0] <<< (2 * FRAC), det);
                    s[4] = div_round((a[2] * a[5] - a[3] * a[4]) <<< FRAC, det);
                    s[5] = div_round((a[1] * a[4] - a[0] * a[5]) <<< FRAC, det);
                    foreach (held[i]) held[i] = clamp32(s[i], ovf);
                end
            end
            default: ;
        endcase
        foreach (held[i]) r.m[i] = held[i];
        r.sing = sing;
        r.ovf = ovf;
        return r;
    endfunction

    function automatic void add_row(req_t op, xform_t v, bit typed, xform_t wm,
                                    logic ws, logic wo);
        row_t r;
        r.op = op;
        r.v = v;
        r.typed = typed;
        r.want.m = wm;
        r.want.sing = ws;
        r.want.ovf = wo;
        rows.push_back(r);
    endfunction

    // One entry: mostly modest Q16.16 values so that compose and invert stay
    // in range, with full-range words and corner values mixed in.
    function automatic logic [31:0] pick_entry();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        if (sel < 70) return $urandom;
        if (sel < 85) return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        case ($urandom_range(0, 4))
            0: return '0;
            1: return ONE;
            2: return -ONE;
            3: return MAXV;
            default: return MINV;
        endcase
    endfunction

    function automatic req_t pick_op();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return REQ_LOAD;
        if (sel < 75) return REQ_COMPOSE;
        if (sel < 95) return REQ_INVERT;
        return REQ_NONE;
    endfunction

    // Presents one word at the falling edge and holds it until accepted.
    // The expectation is queued at the accepting edge.
    task automatic send_word(req_t op, xform_t v, bit typed, result_t want);
        result_t got;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_req_type <= op;
        s_in_m00 <= v[0]; s_in_m01 <= v[1]; s_in_m10 <= v[2];
        s_in_m11 <= v[3]; s_in_tx <= v[4]; s_in_ty <= v[5];
        do @(posedge aclk); while (!s_ready);
        got = apply_request(op, v);
        want_q.push_back(typed ? want : got);
        op_count[op]++;
        if (!calm && $urandom_range(0, 2) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
        end
    endtask

    // Receiver back-pressure: random stall bursts, none in the calm tail.
    initial begin
        forever begin
            @(negedge aclk);
            if (!calm && aresetn && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge aclk);
                @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Compare each accepted result word with the oldest expectation.
    string field_name[6] = '{"m00", "m01", "m10", "m11", "tx", "ty"};
    always @(posedge aclk) begin
        result_t exp_r;
        xform_t  got_m;
        if (aresetn && m_valid && m_ready) begin
            got_m = mk(m_out_m00, m_out_m01, m_out_m10, m_out_m11, m_out_tx, m_out_ty);
            if (want_q.size() == 0) begin
                $error("result word arrived with nothing expected");
                errors++;
            end else begin
                exp_r = want_q.pop_front();
                for (int i = 0; i < 6; i++) begin
                    if (got_m[i] !== exp_r.m[i]) begin
                        $error("out_%s: expected %h, got %h", field_name[i], exp_r.m[i],
                               got_m[i]);
                        errors++;
                    end
                end
                if (m_singular !== exp_r.sing) begin
                    $error("singular: expected %b, got %b", exp_r.sing, m_singular);
                    errors++;
                end
                if (m_overflow !== exp_r.ovf) begin
                    $error("overflow: expected %b, got %b", exp_r.ovf, m_overflow);
                    errors++;
                end
                sing_seen += exp_r.sing;
                ovf_seen += exp_r.ovf;
            end
        end
    end

    // Watchdog: ends the run if neither channel moves a word for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (aresetn && !stim_done || want_q.size() != 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("handshake stalled for %0d cycles", STALL_LIMIT);
                $display("[affine_2d_transform_unit] ERROR");
                $finish;
            end
        end
    end

    initial begin
        xform_t  id, tiny;
        result_t none_r;
        id = mk(ONE, 0, 0, ONE, 0, 0);
        none_r = '0;

        // Directed table. Rows with typed results can be read off directly;
        // the rest go through the predictor.
        add_row(REQ_NONE, mk(MAXV, MINV, MAXV, MINV, MAXV, MINV), 1, id, 0, 0);
        add_row(REQ_INVERT, '0, 1, id, 0, 0);
        add_row(REQ_LOAD, mk(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV), 1,
                mk(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV), 0, 0);
        // Equal entries give a zero determinant: singular, identity back.
        add_row(REQ_INVERT, '0, 1, id, 1, 0);
        add_row(REQ_LOAD, mk(MINV, MINV, MINV, MINV, MINV, MINV), 1,
                mk(MINV, MINV, MINV, MINV, MINV, MINV), 0, 0);
        add_row(REQ_COMPOSE, mk(MINV, MINV, MINV, MINV, MINV, MINV), 0, id, 0, 0);
        add_row(REQ_LOAD, '0, 1, '0, 0, 0);
        add_row(REQ_INVERT, '0, 1, id, 1, 0);
        // Determinant one LSB of Q32 is far below 1e-6.
        tiny = mk(32'd1, 0, 0, 32'd1, 32'd5, 32'd7);
        add_row(REQ_LOAD, tiny, 1, tiny, 0, 0);
        add_row(REQ_INVERT, '0, 1, id, 1, 0);
        // Determinant just at the threshold: not singular, inverse saturates.
        add_row(REQ_LOAD, mk(32'd4295, 0, 0, 32'd1, ONE, -ONE), 0, id, 0, 0);
        add_row(REQ_INVERT, '0, 0, id, 0, 0);
        add_row(REQ_LOAD, mk(32'd4294, 0, 0, 32'd1, 0, 0), 0, id, 0, 0);
        add_row(REQ_INVERT, '0, 1, id, 1, 0);
        // Half-LSB products exercise rounding ties of both signs.
        add_row(REQ_LOAD, mk(32'd1, -32'd1, 32'd3, -32'd3, 32'd1, -32'd1), 0, id, 0, 0);
        add_row(REQ_COMPOSE, mk(32'h8000, 32'h8000, 32'h8000, -32'h8000, MAXV, MINV),
                0, id, 0, 0);
        add_row(REQ_LOAD, mk(2 * ONE, ONE, -ONE, 3 * ONE, 10 * ONE, -4 * ONE), 0, id, 0, 0);
        add_row(REQ_INVERT, '0, 0, id, 0, 0);
        add_row(REQ_INVERT, '0, 0, id, 0, 0);
        add_row(REQ_COMPOSE, mk(MAXV, MINV, MINV, MAXV, MAXV, MINV), 0, id, 0, 0);
        add_row(REQ_INVERT, '0, 0, id, 0, 0);
        add_row(REQ_NONE, mk(32'h1234_5678, 0, 0, 0, 0, 0), 0, id, 0, 0);
        add_row(REQ_LOAD, id, 0, id, 0, 0);
        add_row(REQ_COMPOSE, mk(0, ONE, -ONE, 0, MINV, MAXV), 0, id, 0, 0);

        hold_identity();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) send_word(rows[i].op, rows[i].v, rows[i].typed, rows[i].want);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - N_CALM) calm = 1'b1;
            send_word(pick_op(), mk(pick_entry(), pick_entry(), pick_entry(),
                                    pick_entry(), pick_entry(), pick_entry()), 0, none_r);
        end
        @(negedge aclk);
        s_valid <= 1'b0;
        stim_done = 1'b1;

        wait (want_q.size() == 0);
        repeat (40) @(posedge aclk);

        $display("Covered %0d loads, %0d composes, %0d inverts, %0d unused requests;",
                 op_count[REQ_LOAD], op_count[REQ_COMPOSE], op_count[REQ_INVERT],
                 op_count[REQ_NONE]);
        $display("%0d singular and %0d saturating results, %0d mismatches.",
                 sing_seen, ovf_seen, errors);
        if (errors == 0 && want_q.size() == 0) begin
            $display("[affine_2d_transform_unit] OK");
        end else begin
            $display("[affine_2d_transform_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/a2dtu_pkg.sv
rtl/affine_2d_transform_unit.sv
dv/affine_2d_transform_unit_tb.sv
